[design/rci_pkg.sv]
// ----------------------------------------------------------------------------
// rci_pkg: shared types and constants
// widths, register indexes and request/result types of the ray/cylinder unit
// ----------------------------------------------------------------------------
package rci_pkg;

	// scene geometry
	localparam int SCREEN_WIDTH = 1024;
	localparam int FOCAL_DEPTH  = 887;
	localparam int HALF_WIDTH   = SCREEN_WIDTH / 2;

	// field widths
	localparam int PIX_W     = 10;
	localparam int COORD_W   = 16;
	localparam int RADIUS_W  = 15;
	localparam int CFG_IDX_W = 3;
	localparam int DIST_W    = 32;
	localparam int FRAC_W    = 16;

	// internal widths
	localparam int DX_W        = 18;
	localparam int PROD_W      = 2 * DX_W;
	localparam int R2_W        = 2 * RADIUS_W;
	localparam int A_W         = 34;
	localparam int H_W         = 37;
	localparam int C_W         = 38;
	localparam int SQ_W        = 2 * (H_W - 1);
	localparam int D_W         = SQ_W + 2;
	localparam int DU_W        = 68;
	localparam int RADICAND_W  = DU_W + 32;
	localparam int ROOT_W      = RADICAND_W / 2;
	localparam int SQ_REM_W    = ROOT_W + 2;
	localparam int N_W         = 54;
	localparam int NU_W        = N_W - 1;
	localparam int DIV_REM_W   = A_W + 1;

	// magnitude bounds of the wide product operands: a < 2^32, |h| and |c| < 2^33
	localparam int AMAG_W      = 32;
	localparam int HMAG_W      = 33;
	localparam int CMAG_W      = 33;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAM_X,
		REG_CAM_Z,
		REG_CYL_X,
		REG_CYL_Z,
		REG_CYL_RADIUS
	} reg_idx_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_x;
		logic [PIX_W-1:0] pixel_y;
	} in_req_t;

	typedef struct packed {
		logic              hit;
		logic [DIST_W-1:0] distance;
		logic [PIX_W-1:0]  pixel_y_out;
	} out_res_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] cam_x;
		logic signed [COORD_W-1:0] cam_z;
		logic signed [COORD_W-1:0] cyl_x;
		logic signed [COORD_W-1:0] cyl_z;
		logic [RADIUS_W-1:0]       cyl_radius;
	} cfg_t;

	// per-item data that rides alongside the square root
	typedef struct packed {
		logic                  ok;
		logic signed [H_W-1:0] h;
		logic [A_W-1:0]        a;
		logic [PIX_W-1:0]      pixel_y;
	} side_t;

endpackage

[design/rci_front.sv]
// ----------------------------------------------------------------------------
// rci_front: ray setup and discriminant
// five stages: offsets, products, quadratic terms, wide products, discriminant
// ----------------------------------------------------------------------------
module rci_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         vld_i,
	input  logic [rci_pkg::PIX_W-1:0]    pixel_x,
	input  logic [rci_pkg::PIX_W-1:0]    pixel_y,
	input  rci_pkg::cfg_t                cfg,
	output logic                         vld_o,
	output rci_pkg::side_t               side_o,
	output logic [rci_pkg::DU_W-1:0]     d_o
);

	localparam int DX_W   = rci_pkg::DX_W;
	localparam int PROD_W = rci_pkg::PROD_W;
	localparam int H_W    = rci_pkg::H_W;
	localparam int C_W    = rci_pkg::C_W;
	localparam int A_W    = rci_pkg::A_W;
	localparam int SQ_W   = rci_pkg::SQ_W;
	localparam int D_W    = rci_pkg::D_W;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	logic signed [DX_W-1:0] dx_c, dz_c, ox_c, oz_c;
	logic signed [DX_W-1:0] dx_s1, dz_s1, ox_s1, oz_s1;
	logic [rci_pkg::RADIUS_W-1:0] r_s1;
	logic [rci_pkg::PIX_W-1:0] py_s1, py_s2, py_s3, py_s4, py_s5;

	logic signed [PROD_W-1:0] dxdx_s2, dzdz_s2, dxox_s2, dzoz_s2, oxox_s2, ozoz_s2;
	logic [rci_pkg::R2_W-1:0] r2_s2;

	logic [A_W-1:0]        a_s3, a_s4, a_s5;
	logic signed [H_W-1:0] h_s3, h_s4, h_s5;
	logic signed [C_W-1:0] c_s3;

	logic [H_W-1:0]  habs_c;
	logic [C_W-1:0]  cabs_c;
	logic [SQ_W-1:0] h2_s4, ac_s4;
	logic            cneg_s4;

	logic [D_W-1:0]  d_c;
	logic [rci_pkg::DU_W-1:0] d_s5;
	logic            ok_s5;

	assign dx_c = $signed({{(DX_W-rci_pkg::PIX_W){1'b0}}, pixel_x})
		- DX_W'(rci_pkg::HALF_WIDTH) - DX_W'(cfg.cam_x);
	assign dz_c = DX_W'(rci_pkg::FOCAL_DEPTH) - DX_W'(cfg.cam_z);
	assign ox_c = DX_W'(cfg.cam_x) - DX_W'(cfg.cyl_x);
	assign oz_c = DX_W'(cfg.cam_z) - DX_W'(cfg.cyl_z);

	assign habs_c = h_s3[H_W-1] ? H_W'(-h_s3) : H_W'(h_s3);
	assign cabs_c = c_s3[C_W-1] ? C_W'(-c_s3) : C_W'(c_s3);

	// c >= 0 subtracts a*c, c < 0 adds a*|c|
	assign d_c = cneg_s4 ? ({2'b00, h2_s4} + {2'b00, ac_s4})
		: ({2'b00, h2_s4} - {2'b00, ac_s4});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// offsets
			dx_s1 <= dx_c;
			dz_s1 <= dz_c;
			ox_s1 <= ox_c;
			oz_s1 <= oz_c;
			r_s1  <= cfg.cyl_radius;
			py_s1 <= pixel_y;
			// products
			dxdx_s2 <= dx_s1 * dx_s1;
			dzdz_s2 <= dz_s1 * dz_s1;
			dxox_s2 <= dx_s1 * ox_s1;
			dzoz_s2 <= dz_s1 * oz_s1;
			oxox_s2 <= ox_s1 * ox_s1;
			ozoz_s2 <= oz_s1 * oz_s1;
			r2_s2   <= r_s1 * r_s1;
			py_s2   <= py_s1;
			// quadratic terms
			a_s3  <= A_W'(dxdx_s2 + dzdz_s2);
			h_s3  <= H_W'(dxox_s2) + H_W'(dzoz_s2);
			c_s3  <= C_W'(oxox_s2) + C_W'(ozoz_s2) - C_W'($signed({1'b0, r2_s2}));
			py_s3 <= py_s2;
			// wide products, operands cut to their magnitude bounds
			h2_s4   <= SQ_W'(habs_c[rci_pkg::HMAG_W-1:0] * habs_c[rci_pkg::HMAG_W-1:0]);
			ac_s4   <= SQ_W'(a_s3[rci_pkg::AMAG_W-1:0] * cabs_c[rci_pkg::CMAG_W-1:0]);
			cneg_s4 <= c_s3[C_W-1];
			a_s4    <= a_s3;
			h_s4    <= h_s3;
			py_s4   <= py_s3;
			// discriminant
			d_s5  <= d_c[rci_pkg::DU_W-1:0];
			ok_s5 <= !d_c[D_W-1] && (a_s4 != '0);
			a_s5  <= a_s4;
			h_s5  <= h_s4;
			py_s5 <= py_s4;
		end
	end

	assign vld_o          = vld_s5;
	assign d_o            = d_s5;
	assign side_o.ok      = ok_s5;
	assign side_o.h       = h_s5;
	assign side_o.a       = a_s5;
	assign side_o.pixel_y = py_s5;

endmodule

[design/rci_sqrt.sv]
// ----------------------------------------------------------------------------
// rci_sqrt: pipelined integer square root
// one root bit per stage of floor(sqrt(d * 2^32)), restoring digit method
// ----------------------------------------------------------------------------
module rci_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        vld_i,
	input  rci_pkg::side_t              side_i,
	input  logic [rci_pkg::DU_W-1:0]    d_i,
	output logic                        vld_o,
	output rci_pkg::side_t              side_o,
	output logic [rci_pkg::ROOT_W-1:0]  root_o
);

	localparam int ROOT_W = rci_pkg::ROOT_W;
	localparam int REM_W  = rci_pkg::SQ_REM_W;
	localparam int RAD_W  = rci_pkg::RADICAND_W;

	logic                 vld_s  [1:ROOT_W];
	rci_pkg::side_t       side_s [1:ROOT_W];
	logic [REM_W-1:0]     rem_s  [1:ROOT_W];
	logic [ROOT_W-1:0]    root_s [1:ROOT_W];
	logic [RAD_W-1:0]     rad_s  [1:ROOT_W];

	for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
		logic                 vld_c;
		rci_pkg::side_t       side_c;
		logic [REM_W-1:0]     rem_c, rem_sh, trial;
		logic [ROOT_W-1:0]    root_c;
		logic [RAD_W-1:0]     rad_c;
		logic                 ge;

		if (g == 0) begin : g_head
			assign vld_c  = vld_i;
			assign side_c = side_i;
			assign rem_c  = '0;
			assign root_c = '0;
			assign rad_c  = {d_i, {(RAD_W-rci_pkg::DU_W){1'b0}}};
		end else begin : g_body
			assign vld_c  = vld_s[g];
			assign side_c = side_s[g];
			assign rem_c  = rem_s[g];
			assign root_c = root_s[g];
			assign rad_c  = rad_s[g];
		end

		assign rem_sh = {rem_c[REM_W-3:0], rad_c[RAD_W-1 -: 2]};
		assign trial  = {root_c, 2'b01};
		assign ge     = (rem_sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (adv) begin
				vld_s[g+1] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[g+1] <= side_c;
				rem_s[g+1]  <= ge ? (rem_sh - trial) : rem_sh;
				root_s[g+1] <= {root_c[ROOT_W-2:0], ge};
				rad_s[g+1]  <= {rad_c[RAD_W-3:0], 2'b00};
			end
		end
	end

	assign vld_o  = vld_s[ROOT_W];
	assign side_o = side_s[ROOT_W];
	assign root_o = root_s[ROOT_W];

endmodule

[design/rci_div.sv]
// ----------------------------------------------------------------------------
// rci_div: root selection and pipelined division
// picks the nearest non-negative numerator, divides by a one bit per stage
// ----------------------------------------------------------------------------
module rci_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        vld_i,
	input  rci_pkg::side_t              side_i,
	input  logic [rci_pkg::ROOT_W-1:0]  root_i,
	output logic                        vld_o,
	output rci_pkg::out_res_t           res_o
);

	localparam int N_W    = rci_pkg::N_W;
	localparam int NU_W   = rci_pkg::NU_W;
	localparam int A_W    = rci_pkg::A_W;
	localparam int RW     = rci_pkg::DIV_REM_W;
	localparam int DIST_W = rci_pkg::DIST_W;

	logic signed [N_W-1:0] hs_c, s_c, n1_c, n2_c, n_c;

	logic                      vld_s1, vld_s2;
	logic [NU_W-1:0]           n_s1;
	logic                      hit_s1, hit_s2;
	logic [A_W-1:0]            a_s1, a_s2;
	logic [rci_pkg::PIX_W-1:0] py_s1, py_s2;
	logic                      ovf_c, ovf_s2;
	logic [RW-1:0]             rem_s2;
	logic [DIST_W-1:0]         lo_s2;

	logic                      vld_q  [1:DIST_W];
	logic                      hit_q  [1:DIST_W];
	logic                      ovf_q  [1:DIST_W];
	logic [A_W-1:0]            a_q    [1:DIST_W];
	logic [rci_pkg::PIX_W-1:0] py_q   [1:DIST_W];
	logic [RW-1:0]             rem_q  [1:DIST_W];
	logic [DIST_W-1:0]         lo_q   [1:DIST_W];
	logic [DIST_W-1:0]         quo_q  [1:DIST_W];

	// near root first, far root when the near one is negative
	assign hs_c = N_W'($signed({side_i.h, {rci_pkg::FRAC_W{1'b0}}}));
	assign s_c  = $signed(N_W'(root_i));
	assign n1_c = -hs_c - s_c;
	assign n2_c = -hs_c + s_c;
	assign n_c  = n1_c[N_W-1] ? n2_c : n1_c;

	// quotient reaches 2^32 exactly when the upper numerator bits reach a
	assign ovf_c = (A_W'(n_s1[NU_W-1:DIST_W]) >= a_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s1   <= n_c[NU_W-1:0];
			hit_s1 <= side_i.ok && !n_c[N_W-1];
			a_s1   <= side_i.a;
			py_s1  <= side_i.pixel_y;
			ovf_s2 <= ovf_c;
			rem_s2 <= ovf_c ? '0 : RW'(n_s1[NU_W-1:DIST_W]);
			lo_s2  <= n_s1[DIST_W-1:0];
			hit_s2 <= hit_s1;
			a_s2   <= a_s1;
			py_s2  <= py_s1;
		end
	end

	for (genvar g = 0; g < DIST_W; g++) begin : g_stage
		logic                      vld_c, hit_c, ovf_c2, ge;
		logic [A_W-1:0]            a_c;
		logic [rci_pkg::PIX_W-1:0] py_c;
		logic [RW-1:0]             rem_c, rem_sh;
		logic [DIST_W-1:0]         lo_c, quo_c;

		if (g == 0) begin : g_head
			assign vld_c  = vld_s2;
			assign hit_c  = hit_s2;
			assign ovf_c2 = ovf_s2;
			assign a_c    = a_s2;
			assign py_c   = py_s2;
			assign rem_c  = rem_s2;
			assign lo_c   = lo_s2;
			assign quo_c  = '0;
		end else begin : g_body
			assign vld_c  = vld_q[g];
			assign hit_c  = hit_q[g];
			assign ovf_c2 = ovf_q[g];
			assign a_c    = a_q[g];
			assign py_c   = py_q[g];
			assign rem_c  = rem_q[g];
			assign lo_c   = lo_q[g];
			assign quo_c  = quo_q[g];
		end

		assign rem_sh = {rem_c[RW-2:0], lo_c[DIST_W-1]};
		assign ge     = (rem_sh >= {1'b0, a_c});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[g+1] <= 1'b0;
			end else if (adv) begin
				vld_q[g+1] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				hit_q[g+1] <= hit_c;
				ovf_q[g+1] <= ovf_c2;
				a_q[g+1]   <= a_c;
				py_q[g+1]  <= py_c;
				rem_q[g+1] <= ge ? (rem_sh - {1'b0, a_c}) : rem_sh;
				lo_q[g+1]  <= {lo_c[DIST_W-2:0], 1'b0};
				quo_q[g+1] <= {quo_c[DIST_W-2:0], ge};
			end
		end
	end

	assign vld_o             = vld_q[DIST_W];
	assign res_o.hit         = hit_q[DIST_W];
	assign res_o.distance    = !hit_q[DIST_W] ? '0 : (ovf_q[DIST_W] ? '1 : quo_q[DIST_W]);
	assign res_o.pixel_y_out = py_q[DIST_W];

endmodule

[design/ray_cylinder_intersect_unit.sv]
// pipeline: 90 register stages (5 front, 50 square root, 2 + 32 divide, 1 output)
// throughput: one request per cycle while the output is not stalled; the 50-stage
//   square root and 32-stage divider each retire one bit per stage, so latency is set
//   by their depth, not the rate
// a stalled output freezes the whole pipeline; bubbles are not squeezed out
// reset: asynchronous, active low; clears all valid bits and the configuration
//   registers to zero
// ----------------------------------------------------------------------------
// ray_cylinder_intersect_unit: primary ray against an infinite y-axis cylinder
// per pixel, nearest non-negative hit distance in unsigned 16.16
// ----------------------------------------------------------------------------
module ray_cylinder_intersect_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_write_en,
	input  logic [rci_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rci_pkg::COORD_W-1:0]    cfg_data,
	// request channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  rci_pkg::in_req_t               in_data,
	// result channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output rci_pkg::out_res_t              out_data
);

	rci_pkg::cfg_t cfg_q;

	// single pipeline advance: the output register is free or being drained
	logic adv;

	logic                        fr_vld, sq_vld, dv_vld;
	rci_pkg::side_t              fr_side, sq_side;
	logic [rci_pkg::DU_W-1:0]    fr_d;
	logic [rci_pkg::ROOT_W-1:0]  sq_root;
	rci_pkg::out_res_t           dv_res;

	logic              out_valid_q;
	rci_pkg::out_res_t out_data_q;

	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv;

	// configuration registers, writes to unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				rci_pkg::REG_CAM_X:      cfg_q.cam_x      <= cfg_data;
				rci_pkg::REG_CAM_Z:      cfg_q.cam_z      <= cfg_data;
				rci_pkg::REG_CYL_X:      cfg_q.cyl_x      <= cfg_data;
				rci_pkg::REG_CYL_Z:      cfg_q.cyl_z      <= cfg_data;
				rci_pkg::REG_CYL_RADIUS: cfg_q.cyl_radius <= cfg_data[rci_pkg::RADIUS_W-1:0];
				default: ;
			endcase
		end
	end

	// ray offsets, quadratic coefficients and discriminant
	rci_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.vld_i   (in_valid),
		.pixel_x (in_data.pixel_x),
		.pixel_y (in_data.pixel_y),
		.cfg     (cfg_q),
		.vld_o   (fr_vld),
		.side_o  (fr_side),
		.d_o     (fr_d)
	);

	// square root of the discriminant in unsigned 34.16
	rci_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.vld_i  (fr_vld),
		.side_i (fr_side),
		.d_i    (fr_d),
		.vld_o  (sq_vld),
		.side_o (sq_side),
		.root_o (sq_root)
	);

	// root choice, division by a, saturation
	rci_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.vld_i  (sq_vld),
		.side_i (sq_side),
		.root_i (sq_root),
		.vld_o  (dv_vld),
		.res_o  (dv_res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= dv_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// a miss always reports zero distance
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.hit |-> out_data.distance == '0)
		else $error("miss with nonzero distance");

	// a write to an index past the list leaves the registers alone
	a_cfg_ignore: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write_en && (cfg_index > rci_pkg::REG_CYL_RADIUS) |=> $stable(cfg_q))
		else $error("config changed by out-of-range write");

	// while requests are held off the result register stays loaded
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid_q && out_stall)
		else $error("request stall without a blocked result");

endmodule
